### hw/rtl/iair_pkg.sv
// Shared types and constants for the indexed array insert/remove block.
// Used by the front, queue, back and top-level modules; depends on nothing.
package iair_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int OPC_W   = 2;
   localparam int POS_W   = 5;
   localparam int DATA_W  = 32;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 5;

   localparam logic [OPC_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OPC_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OPC_W-1:0] OP_READ   = 2'd2;

   localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_INSERT,
      ACT_REMOVE,
      ACT_READ
   } action_type;

   // One classified command, passed from the front to the back.
   typedef struct packed {
      action_type               action;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] data_value;
      logic [STAT_W-1:0]        status;
      logic [COUNT_W-1:0]       element_count;
   } cmd_type;

endpackage

### hw/rtl/iair_front.sv
// Front part: accepts request transactions, checks them against its own copy
// of the element count and emits classified commands. Depends on iair_pkg.
module iair_front #(
   parameter int DEPTH = iair_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [iair_pkg::OPC_W-1:0]        req_opcode,
   input  logic [iair_pkg::POS_W-1:0]        req_position,
   input  logic signed [iair_pkg::DATA_W-1:0] req_data_value,
   input  logic                              q_full,
   output logic                              q_push,
   output iair_pkg::cmd_type                 q_cmd
);
   import iair_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CMP_W-1:0] pos_cmp;
   logic [CMP_W-1:0] count_cmp;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;
   assign pos_cmp   = CMP_W'(req_position);
   assign count_cmp = CMP_W'(count_ff);

   always_comb begin
      count_in            = count_ff;
      q_cmd.action        = ACT_NONE;
      q_cmd.position      = req_position;
      q_cmd.data_value    = req_data_value;
      q_cmd.status        = ST_DONE;
      case (req_opcode)
         OP_INSERT: begin
            if (pos_cmp > count_cmp) begin
               q_cmd.status = ST_RANGE;
            end else if (count_ff == FULL_COUNT) begin
               q_cmd.status = ST_FULL;
            end else begin
               q_cmd.action = ACT_INSERT;
               count_in     = count_ff + CNT_W'(1);
            end
         end
         OP_REMOVE: begin
            if (pos_cmp >= count_cmp) begin
               q_cmd.status = ST_RANGE;
            end else begin
               q_cmd.action = ACT_REMOVE;
               count_in     = count_ff - CNT_W'(1);
            end
         end
         OP_READ: begin
            if (pos_cmp >= count_cmp) begin
               q_cmd.status = ST_RANGE;
            end else begin
               q_cmd.action = ACT_READ;
            end
         end
         default: begin
            q_cmd.action = ACT_NONE;
         end
      endcase
      q_cmd.element_count = COUNT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (q_push) begin
         count_ff <= count_in;
      end
   end

endmodule

### hw/rtl/iair_queue.sv
// Two-entry command queue between the front and back parts.
// Depends on iair_pkg for the command type.
module iair_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  iair_pkg::cmd_type push_cmd,
   output logic              full,
   output logic              q_valid,
   input  logic              pop,
   output iair_pkg::cmd_type pop_cmd
);
   import iair_pkg::*;

   cmd_type     slot_ff [2];
   logic        wr_ptr_ff;
   logic        rd_ptr_ff;
   logic [1:0]  fill_ff;
   logic [1:0]  fill_in;

   assign full    = (fill_ff == 2'd2);
   assign q_valid = (fill_ff != 2'd0);
   assign pop_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### hw/rtl/iair_back.sv
// Back part: holds the packed list as a chain of registers, carries out one
// command per cycle while the response is not stalled and registers the response. Depends on iair_pkg.
module iair_back #(
   parameter int DEPTH = iair_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_valid,
   input  iair_pkg::cmd_type                  q_cmd,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [iair_pkg::STAT_W-1:0]        rsp_status,
   output logic [iair_pkg::COUNT_W-1:0]       rsp_element_count,
   output logic signed [iair_pkg::DATA_W-1:0] rsp_read_value
);
   import iair_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CMP_W = (IDX_W > POS_W) ? IDX_W : POS_W;
   // Positions are five bits wide, so only the low entries are ever read out.
   localparam int RD_N  = (DEPTH < 32) ? DEPTH : 32;

   logic signed [DATA_W-1:0]  entries_ff [DEPTH];
   logic [CMP_W-1:0]          pos_cmp;
   logic signed [DATA_W-1:0]  entry_sel;
   logic signed [DATA_W-1:0]  read_in;

   logic                      rsp_valid_ff;
   logic [STAT_W-1:0]         rsp_status_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;
   logic signed [DATA_W-1:0]  rsp_read_ff;

   assign q_pop   = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign pos_cmp = CMP_W'(q_cmd.position);

   for (genvar g = 0; g < DEPTH; g++) begin : g_entry
      localparam logic [CMP_W-1:0] IDX = CMP_W'(g);
      logic signed [DATA_W-1:0] lower;
      logic signed [DATA_W-1:0] upper;
      logic signed [DATA_W-1:0] entry_in;

      if (g > 0) begin : g_lower
         assign lower = entries_ff[g-1];
      end else begin : g_lower_none
         assign lower = entries_ff[g];
      end
      if (g < DEPTH - 1) begin : g_upper
         assign upper = entries_ff[g+1];
      end else begin : g_upper_none
         assign upper = entries_ff[g];
      end

      always_comb begin
         entry_in = entries_ff[g];
         case (q_cmd.action)
            ACT_INSERT: begin
               if (IDX == pos_cmp) begin
                  entry_in = q_cmd.data_value;
               end else if (IDX > pos_cmp) begin
                  entry_in = lower;
               end
            end
            ACT_REMOVE: begin
               if (IDX >= pos_cmp) begin
                  entry_in = upper;
               end
            end
            default: begin
               entry_in = entries_ff[g];
            end
         endcase
      end

      always_ff @(posedge clock) begin
         if (q_pop) begin
            entries_ff[g] <= entry_in;
         end
      end
   end

   always_comb begin
      entry_sel = '0;
      for (int j = 0; j < RD_N; j++) begin
         if (POS_W'(j) == q_cmd.position) begin
            entry_sel = entries_ff[j];
         end
      end
   end

   always_comb begin
      case (q_cmd.action)
         ACT_REMOVE: read_in = entry_sel;
         ACT_READ:   read_in = entry_sel;
         default:    read_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (q_pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_status_ff <= q_cmd.status;
         rsp_count_ff  <= q_cmd.element_count;
         rsp_read_ff   <= read_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_element_count = rsp_count_ff;
   assign rsp_read_value    = rsp_read_ff;

endmodule

### hw/rtl/indexed_array_insert_remove.sv
// Indexed array with insert, remove and read at a position.
// Top level: joins iair_front, iair_queue and iair_back; uses iair_pkg.
//
// Usage:
//   The request channel (req_*) takes an opcode (insert, remove, read), a
//   position and a value. A transaction is accepted at a rising edge where
//   req_valid is high and req_stall is low. Every request produces exactly
//   one response on the rsp_* channel, in order, carrying a status, the
//   element count after the operation and the removed or read entry.
//   An accepted command is registered in the queue, and the back part then
//   carries it out and registers the response on rsp_*, unless rsp_stall
//   holds it. Throughput is one transaction per cycle while the output is
//   not stalled: the list lives in a chain of registers that shifts together.
//   The front checks positions against its own count and queues commands in
//   a two-entry queue; req_stall rises only when that queue is full.
//   When the receiver holds rsp_stall, the response stays on the outputs,
//   the back part stops taking commands and the queue fills behind it.
//   Synchronous reset empties the list and the queue and drops rsp_valid.
//   Entry contents are not cleared; only entries below the count are read.
module indexed_array_insert_remove #(
   parameter int DEPTH = iair_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [iair_pkg::OPC_W-1:0]         req_opcode,
   input  logic [iair_pkg::POS_W-1:0]         req_position,
   input  logic signed [iair_pkg::DATA_W-1:0] req_data_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [iair_pkg::STAT_W-1:0]        rsp_status,
   output logic [iair_pkg::COUNT_W-1:0]       rsp_element_count,
   output logic signed [iair_pkg::DATA_W-1:0] rsp_read_value
);
   import iair_pkg::*;

   logic    q_full;
   logic    q_push;
   logic    q_valid;
   logic    q_pop;
   cmd_type push_cmd;
   cmd_type pop_cmd;

   iair_front #(
      .DEPTH (DEPTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_position   (req_position),
      .req_data_value (req_data_value),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_cmd          (push_cmd)
   );

   iair_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .q_valid  (q_valid),
      .pop      (q_pop),
      .pop_cmd  (pop_cmd)
   );

   iair_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_cmd             (pop_cmd),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_element_count (rsp_element_count),
      .rsp_read_value    (rsp_read_value)
   );

`ifndef NO_ASSERTIONS
   // A full-list rejection can only happen when the count equals the depth.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |-> rsp_element_count == COUNT_W'(DEPTH))
      else $error("full status reported with a count below the depth");

   // A rejected transaction never returns entry data.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_DONE) |-> rsp_read_value == '0)
      else $error("error response carries a nonzero read value");

   // Nothing is in flight right after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !q_valid)
      else $error("response or queued command survived reset");
`endif

endmodule

### test/iair_checker.sv
// Response checker for the indexed array insert/remove block: watches both channels,
// keeps its own copy of the packed list and compares every response against it.
// Depends on iair_pkg for widths and operation and status codes.
module iair_checker #(
   parameter int DEPTH = iair_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [iair_pkg::OPC_W-1:0]         req_opcode,
   input  logic [iair_pkg::POS_W-1:0]         req_position,
   input  logic signed [iair_pkg::DATA_W-1:0] req_data_value,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [iair_pkg::STAT_W-1:0]        rsp_status,
   input  logic [iair_pkg::COUNT_W-1:0]       rsp_element_count,
   input  logic signed [iair_pkg::DATA_W-1:0] rsp_read_value,
   output int                                 pending,
   output int                                 errors
);
   timeunit 1ns;
   timeprecision 1ps;
   import iair_pkg::*;

   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic [COUNT_W-1:0]       element_count;
      logic signed [DATA_W-1:0] read_value;
   } outcome_type;

   logic signed [DATA_W-1:0] list_words [DEPTH];
   int                       list_len;
   outcome_type              outcome_q[$];

   // Applies one command to the list copy and returns the response it should give.
   function automatic outcome_type apply_command(input logic [OPC_W-1:0] opcode,
                                                 input logic [POS_W-1:0] position,
                                                 input logic signed [DATA_W-1:0] value);
      outcome_type result;
      int          pos;
      pos = int'(position);
      result.status = ST_DONE;
      result.read_value = '0;
      case (opcode)
         OP_INSERT: begin
            if (pos > list_len) begin
               result.status = ST_RANGE;
            end else if (list_len >= DEPTH) begin
               result.status = ST_FULL;
            end else begin
               for (int i = list_len; i > pos; i--) begin
                  list_words[i] = list_words[i-1];
               end
               list_words[pos] = value;
               list_len++;
            end
         end
         OP_REMOVE: begin
            if (pos >= list_len) begin
               result.status = ST_RANGE;
            end else begin
               result.read_value = list_words[pos];
               for (int i = pos; i + 1 < list_len; i++) begin
                  list_words[i] = list_words[i+1];
               end
               list_len--;
            end
         end
         OP_READ: begin
            if (pos >= list_len) begin
               result.status = ST_RANGE;
            end else begin
               result.read_value = list_words[pos];
            end
         end
         default: ;
      endcase
      result.element_count = COUNT_W'(list_len);
      return result;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         list_len = 0;
         outcome_q.delete();
         pending = 0;
         errors = 0;
      end else begin
         // A response can never belong to a request accepted at the same edge.
         if (rsp_valid && !rsp_stall) begin
            if (outcome_q.size() == 0) begin
               errors++;
               $display("%0t: response with no transaction pending: status %0d count %0d value %0d",
                        $time, rsp_status, rsp_element_count, rsp_read_value);
            end else begin
               want = outcome_q.pop_front();
               if (rsp_status !== want.status) begin
                  errors++;
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_status);
               end
               if (rsp_element_count !== want.element_count) begin
                  errors++;
                  $display("%0t: element count expected %0d actual %0d",
                           $time, want.element_count, rsp_element_count);
               end
               if (rsp_read_value !== want.read_value) begin
                  errors++;
                  $display("%0t: read value expected %0d actual %0d",
                           $time, want.read_value, rsp_read_value);
               end
            end
         end
         if (req_valid && !req_stall) begin
            outcome_q.push_back(apply_command(req_opcode, req_position, req_data_value));
         end
         pending = outcome_q.size();
      end
   end

endmodule

### test/tb.sv
// Top of the testbench for indexed_array_insert_remove: clock, reset, stimulus and verdict.
// Depends on iair_pkg, the block itself and iair_checker, which does all the comparing.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import iair_pkg::*;

   localparam int DEPTH = DEPTH_DEFAULT;
   localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;
   localparam int PHASES = 6;
   localparam int PHASE_ITEMS = 242;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [OPC_W-1:0]         req_opcode = OP_READ;
   logic [POS_W-1:0]         req_position = '0;
   logic signed [DATA_W-1:0] req_data_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [STAT_W-1:0]        rsp_status;
   logic [COUNT_W-1:0]       rsp_element_count;
   logic signed [DATA_W-1:0] rsp_read_value;
   int                       pending;
   int                       errors;

   // Idle knobs, in percent, changed from phase to phase.
   int gap_pct = 20;
   int stall_pct = 20;
   int stall_left = 0;
   // Number of entries the list holds after every accepted transaction so far.
   int fill = 0;

   indexed_array_insert_remove #(.DEPTH(DEPTH)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_opcode(req_opcode),
      .req_position(req_position), .req_data_value(req_data_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_element_count(rsp_element_count), .rsp_read_value(rsp_read_value)
   );

   iair_checker #(.DEPTH(DEPTH)) list_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_opcode(req_opcode),
      .req_position(req_position), .req_data_value(req_data_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_element_count(rsp_element_count), .rsp_read_value(rsp_read_value),
      .pending(pending), .errors(errors)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("tb: errors");
      $finish;
   end

   // Receiver back-pressure: mostly short stalls, now and then a long one.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (!reset && $urandom_range(0, 99) < stall_pct) begin
         rsp_stall <= 1'b1;
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                   : $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Drives one transaction, waits for it to be taken, then maybe idles a while.
   task automatic send_command(input logic [OPC_W-1:0] opcode, input int position,
                               input logic signed [DATA_W-1:0] value);
      int gap;
      req_valid <= 1'b1;
      req_opcode <= opcode;
      req_position <= POS_W'(position);
      req_data_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (opcode == OP_INSERT && position <= fill && fill < DEPTH) begin
         fill++;
      end else if (opcode == OP_REMOVE && position < fill) begin
         fill--;
      end
      gap = 0;
      if ($urandom_range(0, 99) < gap_pct) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 30) : $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random(input int insert_pct, input int remove_pct);
      int                       roll;
      int                       position;
      logic [OPC_W-1:0]         opcode;
      logic signed [DATA_W-1:0] value;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         opcode = OP_UNUSED;
      end else if (roll < insert_pct) begin
         opcode = OP_INSERT;
      end else if (roll < insert_pct + remove_pct) begin
         opcode = OP_REMOVE;
      end else begin
         opcode = OP_READ;
      end
      // Mostly legal positions so the list actually grows and shrinks.
      if ($urandom_range(0, 99) < 12) begin
         position = $urandom_range(0, 31);
      end else if (opcode == OP_INSERT) begin
         position = $urandom_range(0, fill);
      end else begin
         position = (fill == 0) ? 0 : $urandom_range(0, fill - 1);
      end
      case ($urandom_range(0, 11))
         0: value = 32'sh7fffffff;
         1: value = 32'sh80000000;
         2: value = '0;
         3: value = -1;
         default: value = $urandom;
      endcase
      send_command(opcode, position, value);
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (pending != 0);
   endtask

   initial begin
      int insert_mix [PHASES] = '{70, 30, 45, 80, 20, 45};
      int remove_mix [PHASES] = '{20, 60, 40, 10, 70, 40};
      int gap_mix    [PHASES] = '{30, 30,  0, 60, 15, 30};
      int stall_mix  [PHASES] = '{30,  0,  0, 50, 20, 30};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Empty list, out-of-range positions, the unused opcode and extreme values.
      send_command(OP_READ, 0, 0);
      send_command(OP_REMOVE, 0, 0);
      send_command(OP_INSERT, 1, 5);
      send_command(OP_UNUSED, 31, -1);
      send_command(OP_INSERT, 0, 32'sh7fffffff);
      send_command(OP_INSERT, 0, 32'sh80000000);
      send_command(OP_INSERT, 2, 0);
      send_command(OP_INSERT, 1, -1);
      send_command(OP_READ, 31, 0);
      send_command(OP_READ, 3, 0);
      send_command(OP_REMOVE, 1, 0);
      send_command(OP_REMOVE, 2, 0);
      send_command(OP_INSERT, 31, 7);
      while (fill < DEPTH) send_command(OP_INSERT, $urandom_range(0, fill), $urandom);
      // A full list: an in-range insert reports full, a position past the end wins.
      send_command(OP_INSERT, DEPTH, 1);
      send_command(OP_INSERT, DEPTH + 1, 1);
      send_command(OP_READ, DEPTH - 1, 0);
      send_command(OP_REMOVE, DEPTH - 1, 0);
      send_command(OP_REMOVE, 0, 0);

      for (int phase = 0; phase < PHASES; phase++) begin
         gap_pct <= gap_mix[phase];
         stall_pct <= stall_mix[phase];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_random(insert_mix[phase], remove_mix[phase]);
         end
         // Let the block run dry before the next phase starts.
         req_valid <= 1'b0;
         wait_drained();
         @(posedge clock);
      end

      wait_drained();
      repeat (8) @(posedge clock);
      @(negedge clock);
      if (errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

### filelist.f
hw/rtl/iair_pkg.sv
hw/rtl/iair_front.sv
hw/rtl/iair_queue.sv
hw/rtl/iair_back.sv
hw/rtl/indexed_array_insert_remove.sv
test/iair_checker.sv
test/tb.sv
